// ===== hdl/sfd_pkg.sv =====
// Shared types and constants for the sum-checked frame deframer.
package sfd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned READING_W = 16;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hFF;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_CSUM_ERR = 1'b1;

  typedef logic [1:0] fill_t;

  localparam fill_t FILL_EMPTY = 2'd0;
  localparam fill_t FILL_ONE   = 2'd1;
  localparam fill_t FILL_TWO   = 2'd2;
  localparam fill_t FILL_THREE = 2'd3;

  typedef struct packed {
    logic              sum_ok;
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
  } sfd_rec_t;

endpackage

// ===== hdl/sfd_if.sv =====
// Valid/ready channel interfaces for received bytes and decoded results.
interface sfd_byte_if import sfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_result_if import sfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [READING_W-1:0] reading;
  logic                 status;

  modport source (output valid, output reading, output status, input ready);
  modport sink (input valid, input reading, input status, output ready);
endinterface

// ===== hdl/sfd_front.sv =====
// Frame assembler: skips stray bytes, buffers frames, checks the sum and realigns.
module sfd_front import sfd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              in_ready,
  input  logic              q_full,
  output logic              push,
  output sfd_rec_t          push_rec
);

  logic [BYTE_W-1:0] hdr_r;
  logic [BYTE_W-1:0] buf_r [3];
  logic [BYTE_W-1:0] buf_nxt [3];
  fill_t             fill_r;
  fill_t             fill_nxt;

  logic              accept;
  logic              skip;
  logic              complete;
  logic [BYTE_W-1:0] sum;
  logic              sum_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign skip     = (fill_r == FILL_EMPTY) && (in_byte != hdr_r);
  assign complete = (fill_r == FILL_THREE);
  assign sum      = buf_r[0] + buf_r[1] + buf_r[2];
  assign sum_ok   = (sum == in_byte);

  assign push            = accept && complete;
  assign push_rec.sum_ok = sum_ok;
  assign push_rec.hi     = buf_r[1];
  assign push_rec.lo     = buf_r[2];

  always_comb begin
    buf_nxt[0] = buf_r[0];
    buf_nxt[1] = buf_r[1];
    buf_nxt[2] = buf_r[2];
    fill_nxt   = fill_r;
    if (accept && !skip) begin
      if (!complete) begin
        buf_nxt[fill_r] = in_byte;
        fill_nxt        = fill_r + 2'd1;
      end else if (sum_ok) begin
        fill_nxt = FILL_EMPTY;
      end else if (buf_r[1] == hdr_r) begin
        buf_nxt[0] = buf_r[1];
        buf_nxt[1] = buf_r[2];
        buf_nxt[2] = in_byte;
        fill_nxt   = FILL_THREE;
      end else if (buf_r[2] == hdr_r) begin
        buf_nxt[0] = buf_r[2];
        buf_nxt[1] = in_byte;
        fill_nxt   = FILL_TWO;
      end else if (in_byte == hdr_r) begin
        buf_nxt[0] = in_byte;
        fill_nxt   = FILL_ONE;
      end else begin
        fill_nxt = FILL_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= HEADER_RESET;
      fill_r <= FILL_EMPTY;
    end else begin
      if (cfg_we) begin
        hdr_r <= cfg_wdata;
      end
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

// ===== hdl/sfd_fifo.sv =====
// Short result queue between the frame assembler and the output stage.
module sfd_fifo import sfd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sfd_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output sfd_rec_t head_rec
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sfd_rec_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head_rec  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ===== hdl/sfd_back.sv =====
// Output stage: formats queued frame results and holds them for the sink.
module sfd_back import sfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  sfd_rec_t             q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [READING_W-1:0] out_reading,
  output logic                 out_status
);

  logic                 valid_r;
  logic [READING_W-1:0] reading_r;
  logic                 status_r;

  assign q_pop       = q_not_empty && (!valid_r || out_ready);
  assign out_valid   = valid_r;
  assign out_reading = reading_r;
  assign out_status  = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_head.sum_ok) begin
        reading_r <= {q_head.hi, q_head.lo};
        status_r  <= STATUS_OK;
      end else begin
        reading_r <= '0;
        status_r  <= STATUS_CSUM_ERR;
      end
    end
  end

endmodule

// ===== hdl/sum_checked_frame_deframer_core.sv =====
// Top level of the sum-checked frame deframer.
// The block takes one received byte per clock cycle while the result queue has room,
// and builds four-byte frames of a header byte, a high data byte, a low data byte and a
// checksum equal to the sum of the first three modulo 256; bytes other than the header
// are skipped while no frame is open. A good frame yields its 16-bit reading with
// status 0, a bad one a zero reading with status 1, after which the buffer realigns on
// the next buffered header byte. The result passes through the result queue, which the
// frame assembler writes in the cycle of the request that completes the frame, and then
// the output register. The queue holds QUEUE_DEPTH entries, so the input keeps taking a
// request per cycle while the output is stalled, until the queue fills.
module sum_checked_frame_deframer_core import sfd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata,
  sfd_byte_if.sink          in_ch,
  sfd_result_if.source      out_ch
);

  logic     q_push;
  sfd_rec_t q_push_rec;
  logic     q_full;
  logic     q_pop;
  logic     q_not_empty;
  sfd_rec_t q_head;

  sfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.rx_byte),
    .in_ready  (in_ch.ready),
    .q_full    (q_full),
    .push      (q_push),
    .push_rec  (q_push_rec)
  );

  sfd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (q_push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_rec  (q_head)
  );

  sfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_reading (out_ch.reading),
    .out_status  (out_ch.status)
  );

endmodule

// ===== hdl/sfd_checker.sv =====
// Port-level assertions for the deframer top level and their bind statement.
module sfd_checker import sfd_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [READING_W-1:0] out_reading,
  input logic                 out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_reading) && $stable(out_status)))
    else $error("Stalled result changed or was withdrawn.");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_CSUM_ERR)) |-> (out_reading == '0))
    else $error("Checksum error result carries a nonzero reading.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result offered right after reset.");

endmodule

bind sum_checked_frame_deframer_core sfd_checker u_sfd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_reading (out_ch.reading),
  .out_status  (out_ch.status)
);
